[hdl/ray_box_slab_intersect_macros.svh]
// Assertion macros shared by the checker of the ray / rectangle slab test.
// Include by bare file name; macros use aclk, RBSI_ASSERT also aresetn.
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RBSI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define RBSI_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/rbsi_pkg.sv]
// Package for the ray / rectangle slab test: widths, beat layout, divider step,
// saturation. No dependencies.
package rbsi_pkg;

    localparam int ORG_W    = 24;                 // origin, Q16.8
    localparam int DIR_W    = 16;                 // direction, Q1.14
    localparam int EDGE_W   = 16;                 // rectangle edge and size
    localparam int FRAC_DIR = 14;                 // fraction bits of direction
    localparam int NUM_W    = 28;                 // edge minus origin, Q.8
    localparam int DVD_W    = NUM_W + FRAC_DIR;   // dividend width
    localparam int REM_W    = DIR_W;              // remainder width
    localparam int BPS      = 6;                  // quotient bits per stage
    localparam int NDIV     = DVD_W / BPS;        // divider stages
    localparam int NLANE    = 4;                  // x lo, x hi, y lo, y hi
    localparam int T_W      = 44;                 // exact distance width
    localparam int OUT_W    = 32;                 // reported distance width
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 72;

    localparam logic signed [T_W-1:0] T_UNB  = 44'sh100_0000_0000;
    localparam logic signed [T_W-1:0] T_SMAX = 44'sh000_7FFF_FFFF;
    localparam logic signed [T_W-1:0] T_SMIN = -44'sh000_8000_0000;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DVD_W-1:0] dq;    // dividend shifts out on top, quotient in below
    } div_t;

    typedef struct packed {
        logic [NLANE-1:0] neg;
        logic [DIR_W-1:0] dmag_x;
        logic [DIR_W-1:0] dmag_y;
        logic             zero_x;
        logic             zero_y;
        logic             in_x;
        logic             in_y;
    } side_t;

    // Retire BPS quotient bits of a restoring division.
    function automatic div_t div_step(div_t din, logic [DIR_W-1:0] d);
        logic [REM_W:0]   r;
        logic [DVD_W-1:0] q;
        div_t             dout;
        r = {1'b0, din.rem};
        q = din.dq;
        for (int i = 0; i < BPS; i++) begin
            r = {r[REM_W-1:0], q[DVD_W-1]};
            q = {q[DVD_W-2:0], 1'b0};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[0] = 1'b1;
            end
        end
        dout.rem = r[REM_W-1:0];
        dout.dq  = q;
        return dout;
    endfunction

    // Clamp an exact distance to the 32 bit signed range.
    function automatic logic [OUT_W-1:0] sat32(logic signed [T_W-1:0] v);
        logic [OUT_W-1:0] r;
        if (v > T_SMAX) begin
            r = T_SMAX[OUT_W-1:0];
        end else if (v < T_SMIN) begin
            r = T_SMIN[OUT_W-1:0];
        end else begin
            r = v[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/ray_box_slab_intersect.sv]
// Ray versus axis-aligned rectangle slab test, pipelined, one beat per cycle.
// Depends on rbsi_pkg.
//
//   channel | dir | fields (lowest bit up)
//   --------+-----+------------------------------------------------------------
//   s_      | in  | origin_x, origin_y, dir_x, dir_y, box_left, box_top,
//           |     | box_width, box_height
//   m_      | out | hit, t_enter, t_exit
//
// The pipeline has one prepare stage, seven divider stages of six quotient
// bits each, order, combine and output register. Throughput is one beat a cycle.
// Each stage advances when it is empty or its successor advances, so a stall on
// m_tready fills bubbles first and loses nothing. aresetn clears valid bits only.
module ray_box_slab_intersect
    import rbsi_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // origin_x, origin_y, dir_x, dir_y, box_left, box_top, box_width, box_height
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // hit, t_enter, t_exit, zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int NV   = NDIV + 4;
    localparam int S_ORD = NDIV + 1;
    localparam int S_CMB = NDIV + 2;
    localparam int S_OUT = NDIV + 3;

    logic [NV-1:0] v_reg;
    logic [NV-1:0] ce;

    div_t  dv_reg [0:NDIV][0:NLANE-1];
    side_t sb_reg [0:NDIV];

    // Advance a stage when it is empty or its successor moves.
    always_comb begin
        ce[NV-1] = !v_reg[NV-1] || m_tready;
        for (int i = NV - 2; i >= 0; i--) begin
            ce[i] = !v_reg[i] || ce[i+1];
        end
    end

    assign s_tready = ce[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            if (ce[0]) begin
                v_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NV; i++) begin
                if (ce[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // Prepare: slab numerators, magnitudes, signs, zero direction checks.
    logic [ORG_W-1:0]        org_x, org_y;
    logic [DIR_W-1:0]        dir_x, dir_y;
    logic [EDGE_W-1:0]       box_left, box_top, box_width, box_height;
    logic signed [NUM_W-1:0] org_xe, org_ye;
    logic signed [EDGE_W+1:0] right, bottom;
    logic signed [NUM_W-1:0] edge_e [0:NLANE-1];
    logic signed [NUM_W-1:0] num    [0:NLANE-1];
    div_t                    dv_next [0:NLANE-1];
    side_t                   sb_next;

    assign org_x      = s_tdata[23:0];
    assign org_y      = s_tdata[47:24];
    assign dir_x      = s_tdata[63:48];
    assign dir_y      = s_tdata[79:64];
    assign box_left   = s_tdata[95:80];
    assign box_top    = s_tdata[111:96];
    assign box_width  = s_tdata[127:112];
    assign box_height = s_tdata[143:128];

    always_comb begin
        org_xe    = {{(NUM_W-ORG_W){org_x[ORG_W-1]}}, org_x};
        org_ye    = {{(NUM_W-ORG_W){org_y[ORG_W-1]}}, org_y};
        right     = {{2{box_left[EDGE_W-1]}}, box_left} + {2'b00, box_width};
        bottom    = {{2{box_top[EDGE_W-1]}}, box_top} + {2'b00, box_height};
        edge_e[0] = {{(NUM_W-EDGE_W-8){box_left[EDGE_W-1]}}, box_left, 8'h00};
        edge_e[1] = {{(NUM_W-EDGE_W-10){right[EDGE_W+1]}}, right, 8'h00};
        edge_e[2] = {{(NUM_W-EDGE_W-8){box_top[EDGE_W-1]}}, box_top, 8'h00};
        edge_e[3] = {{(NUM_W-EDGE_W-10){bottom[EDGE_W+1]}}, bottom, 8'h00};
        for (int l = 0; l < NLANE; l++) begin
            num[l] = edge_e[l] - ((l < 2) ? org_xe : org_ye);
            sb_next.neg[l] = num[l][NUM_W-1] ^ ((l < 2) ? dir_x[DIR_W-1] : dir_y[DIR_W-1]);
            dv_next[l].rem = '0;
            dv_next[l].dq  = {(num[l][NUM_W-1] ? -num[l] : num[l]), {FRAC_DIR{1'b0}}};
        end
        sb_next.dmag_x = dir_x[DIR_W-1] ? -dir_x : dir_x;
        sb_next.dmag_y = dir_y[DIR_W-1] ? -dir_y : dir_y;
        sb_next.zero_x = (dir_x == '0);
        sb_next.zero_y = (dir_y == '0);
        sb_next.in_x   = (org_xe > edge_e[0]) && (org_xe < edge_e[1]);
        sb_next.in_y   = (org_ye > edge_e[2]) && (org_ye < edge_e[3]);
    end

    // Prepare register and divider stages.
    always_ff @(posedge aclk) begin
        if (ce[0]) begin
            sb_reg[0] <= sb_next;
            for (int l = 0; l < NLANE; l++) begin
                dv_reg[0][l] <= dv_next[l];
            end
        end
        for (int k = 1; k <= NDIV; k++) begin
            if (ce[k]) begin
                sb_reg[k] <= sb_reg[k-1];
                for (int l = 0; l < NLANE; l++) begin
                    dv_reg[k][l] <= div_step(dv_reg[k-1][l],
                        (l < 2) ? sb_reg[k-1].dmag_x : sb_reg[k-1].dmag_y);
                end
            end
        end
    end

    // Order: apply signs, substitute unbounded axes, sort each pair.
    logic signed [T_W-1:0] t_q [0:NLANE-1];
    logic signed [T_W-1:0] xmin_next, xmax_next, ymin_next, ymax_next;
    logic                  ok_next;
    logic signed [T_W-1:0] xmin_reg, xmax_reg, ymin_reg, ymax_reg;
    logic                  ok_reg;

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            t_q[l] = {{(T_W-DVD_W){1'b0}}, dv_reg[NDIV][l].dq};
            if (sb_reg[NDIV].neg[l]) begin
                t_q[l] = -t_q[l];
            end
        end
        if (sb_reg[NDIV].zero_x) begin
            xmin_next = -T_UNB;
            xmax_next = T_UNB;
        end else begin
            xmin_next = (t_q[0] > t_q[1]) ? t_q[1] : t_q[0];
            xmax_next = (t_q[0] > t_q[1]) ? t_q[0] : t_q[1];
        end
        if (sb_reg[NDIV].zero_y) begin
            ymin_next = -T_UNB;
            ymax_next = T_UNB;
        end else begin
            ymin_next = (t_q[2] > t_q[3]) ? t_q[3] : t_q[2];
            ymax_next = (t_q[2] > t_q[3]) ? t_q[2] : t_q[3];
        end
        ok_next = (!sb_reg[NDIV].zero_x || sb_reg[NDIV].in_x) &&
                  (!sb_reg[NDIV].zero_y || sb_reg[NDIV].in_y);
    end

    always_ff @(posedge aclk) begin
        if (ce[S_ORD]) begin
            xmin_reg <= xmin_next;
            xmax_reg <= xmax_next;
            ymin_reg <= ymin_next;
            ymax_reg <= ymax_next;
            ok_reg   <= ok_next;
        end
    end

    // Combine: reject disjoint intervals and missed parallel slabs, intersect the rest.
    logic                  rej_next, rej_reg;
    logic signed [T_W-1:0] enter_next, leave_next, enter_reg, leave_reg;

    always_comb begin
        rej_next   = !ok_reg || (xmin_reg > ymax_reg) || (ymin_reg > xmax_reg);
        enter_next = (ymin_reg > xmin_reg) ? ymin_reg : xmin_reg;
        leave_next = (ymax_reg < xmax_reg) ? ymax_reg : xmax_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce[S_CMB]) begin
            rej_reg   <= rej_next;
            enter_reg <= enter_next;
            leave_reg <= leave_next;
        end
    end

    // Output: hit test and saturation.
    logic             hit_next, hit_reg;
    logic [OUT_W-1:0] t_enter_next, t_exit_next, t_enter_reg, t_exit_reg;

    always_comb begin
        hit_next     = !rej_reg && (enter_reg <= leave_reg) && !leave_reg[T_W-1];
        t_enter_next = rej_reg ? '0 : sat32(enter_reg);
        t_exit_next  = rej_reg ? '0 : sat32(leave_reg);
    end

    always_ff @(posedge aclk) begin
        if (ce[S_OUT]) begin
            hit_reg     <= hit_next;
            t_enter_reg <= t_enter_next;
            t_exit_reg  <= t_exit_next;
        end
    end

    assign m_tvalid = v_reg[NV-1];
    assign m_tdata  = {{(M_DATA_W-1-2*OUT_W){1'b0}}, t_exit_reg, t_enter_reg, hit_reg};

endmodule

[hdl/rbsi_checker.sv]
// Port-level checker for the ray / rectangle slab test, bound to the top level.
// Depends on rbsi_pkg and ray_box_slab_intersect_macros.svh.
`include "ray_box_slab_intersect_macros.svh"

module rbsi_checker
    import rbsi_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    logic signed [OUT_W-1:0] t_enter, t_exit;
    logic                    hit_ok;

    assign t_enter = m_tdata[32:1];
    assign t_exit  = m_tdata[64:33];
    assign hit_ok  = (t_enter <= t_exit) && !t_exit[OUT_W-1];

    // Hold a stalled result beat.
    `RBSI_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped")
    `RBSI_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata), "stalled beat changed")
    // A hit lies in a nonempty interval that ends at or after the origin.
    `RBSI_ASSERT(a_hit_interval, m_tvalid && m_tdata[0] |-> hit_ok, "hit with bad interval")
    // Accept input whenever the output register is empty.
    `RBSI_ASSERT(a_ready_drained, !m_tvalid |-> s_tready, "input stalled on empty output")
    // Drain the pipeline on reset.
    `RBSI_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind ray_box_slab_intersect rbsi_checker u_rbsi_checker (.*);
